// ===== sv/edi_pkg.sv =====
// ----------------------------------------------------------------------------
// Effective diameter interpolator package
// Shared widths, register map, sequencer encodings and the microcode table.
// ----------------------------------------------------------------------------
package edi_pkg;

  // Payload widths
  localparam int DIST_W = 8;
  localparam int PAIR_W = 48;
  localparam int PCT_W  = 17;
  localparam int FRAC_W = 16;
  localparam int DIAM_W = DIST_W + FRAC_W;

  // Percentile constants, unsigned Q1.16
  localparam logic [PCT_W-1:0] PCT_ONE   = 17'd65536;
  localparam logic [PCT_W-1:0] PCT_RESET = 17'd58982;

  // Parameter defaults
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int COUNT_BITS_DEF  = 48;

  // Configuration port and register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_IS_PDF = 1'b1;

  // Microcode step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] S_MUL_LO = 4'd1;
  localparam logic [PC_W-1:0] S_MUL_HI = 4'd2;
  localparam logic [PC_W-1:0] S_READ   = 4'd3;
  localparam logic [PC_W-1:0] S_CMP    = 4'd4;
  localparam logic [PC_W-1:0] S_ADV    = 4'd5;
  localparam logic [PC_W-1:0] S_NOHIT  = 4'd6;
  localparam logic [PC_W-1:0] S_HIT    = 4'd7;
  localparam logic [PC_W-1:0] S_DIV    = 4'd8;
  localparam logic [PC_W-1:0] S_FIN    = 4'd9;
  localparam logic [PC_W-1:0] S_OUT    = 4'd10;
  localparam logic [PC_W-1:0] S_DONE   = 4'd11;

  // Datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL_LO   = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL_HI   = 4'd3;
  localparam logic [OP_W-1:0] OP_CMP      = 4'd4;
  localparam logic [OP_W-1:0] OP_ADV      = 4'd5;
  localparam logic [OP_W-1:0] OP_RES_LAST = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd8;
  localparam logic [OP_W-1:0] OP_RES_DIV  = 4'd9;
  localparam logic [OP_W-1:0] OP_CLEAR    = 4'd10;

  // Jump conditions
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
  localparam logic [COND_W-1:0] C_NO_CLOSE = 3'd2;
  localparam logic [COND_W-1:0] C_HIT      = 3'd3;
  localparam logic [COND_W-1:0] C_MORE     = 3'd4;
  localparam logic [COND_W-1:0] C_SPECIAL  = 3'd5;
  localparam logic [COND_W-1:0] C_DIV_MORE = 3'd6;
  localparam logic [COND_W-1:0] C_OUT_WAIT = 3'd7;

  // One control word of the program
  typedef struct packed {
    logic              in_ready;
    logic              out_valid;
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } edi_uword_t;

  // Status flags that the datapath hands to the sequencer
  typedef struct packed {
    logic no_close;
    logic hit;
    logic more;
    logic special;
    logic div_more;
    logic out_wait;
  } edi_flags_t;

  // The program. A step jumps to its target when its condition holds,
  // otherwise it falls through to the next step.
  function automatic edi_uword_t ucode_rom(input logic [PC_W-1:0] pc);
    edi_uword_t w;
    case (pc)
      S_IDLE:   w = '{in_ready: 1'b1, out_valid: 1'b0, op: OP_LOAD,
                      cond: C_NO_CLOSE, target: S_IDLE};
      S_MUL_LO: w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_MUL_LO,
                      cond: C_NEVER, target: S_IDLE};
      S_MUL_HI: w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_MUL_HI,
                      cond: C_NEVER, target: S_IDLE};
      S_READ:   w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_NONE,
                      cond: C_NEVER, target: S_IDLE};
      S_CMP:    w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_CMP,
                      cond: C_HIT, target: S_HIT};
      S_ADV:    w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_ADV,
                      cond: C_MORE, target: S_READ};
      S_NOHIT:  w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_RES_LAST,
                      cond: C_ALWAYS, target: S_OUT};
      S_HIT:    w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_DIV_INIT,
                      cond: C_SPECIAL, target: S_OUT};
      S_DIV:    w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_DIV_STEP,
                      cond: C_DIV_MORE, target: S_DIV};
      S_FIN:    w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_RES_DIV,
                      cond: C_NEVER, target: S_IDLE};
      S_OUT:    w = '{in_ready: 1'b0, out_valid: 1'b1, op: OP_NONE,
                      cond: C_OUT_WAIT, target: S_OUT};
      S_DONE:   w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_CLEAR,
                      cond: C_ALWAYS, target: S_IDLE};
      default:  w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_NONE,
                      cond: C_ALWAYS, target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/edi_ifs.sv =====
// ----------------------------------------------------------------------------
// Effective diameter interpolator channels
// Valid/ready channels for histogram entries and for diameter results.
// ----------------------------------------------------------------------------
interface edi_in_if;
  import edi_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [PAIR_W-1:0] pair_count;
  logic              last_entry;

  modport source (output valid, distance, pair_count, last_entry, input ready);
  modport sink   (input valid, distance, pair_count, last_entry, output ready);
endinterface

interface edi_out_if;
  import edi_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIAM_W-1:0] effective_diameter;
  logic              overflow;

  modport source (output valid, effective_diameter, overflow, input ready);
  modport sink   (input valid, effective_diameter, overflow, output ready);
endinterface

// ===== sv/effective_diameter_interpolator.sv =====
// ----------------------------------------------------------------------------
// Effective diameter interpolator
// Loads a distance histogram and reports the interpolated effective diameter.
// ----------------------------------------------------------------------------
// Histogram entries are taken one beat per clock while the block is loading.
// The beat that carries last_entry closes the histogram; the block then stops
// taking entries until its result beat has been taken. Closing multiplies the
// threshold in low and high halves, reads, compares and advances over the stored
// entries up to the first one above the threshold, then runs a 16-step restoring
// divide for the fraction unless the hit is the first entry or a flat step; with
// no hit the last distance stands. The pace is set by the single read port of
// the entry memory and the one-bit-per-cycle divider. No clearing pass is needed
// after reset. Results are unsigned Q8.16; overflow reports a histogram with
// more entries than MAX_ENTRIES, whose extra entries are dropped.
module effective_diameter_interpolator #(
  parameter int MAX_ENTRIES = edi_pkg::MAX_ENTRIES_DEF,
  parameter int COUNT_BITS  = edi_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  edi_in_if.sink                          in_ch,
  edi_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [edi_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [edi_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [edi_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import edi_pkg::*;

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int TW    = COUNT_BITS + FRAC_W;
  localparam int HW    = (COUNT_BITS + 1) / 2;
  localparam int KW    = $clog2(FRAC_W);
  localparam int MEM_W = DIST_W + COUNT_BITS;
  localparam int PLO_W = PCT_W + HW;
  localparam int PHI_W = PCT_W + COUNT_BITS - HW;
  localparam logic [PAIR_W-1:0] PAIR_CAP = {PAIR_W{1'b1}} >> (PAIR_W - COUNT_BITS);

  // Configuration registers
  logic [PCT_W-1:0]     pct_r;
  logic                 pdf_r;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  // Histogram bookkeeping
  logic [CNT_W-1:0]      cnt_r;
  logic [COUNT_BITS-1:0] run_r;
  logic                  ovf_r;
  logic [COUNT_BITS-1:0] last_cum_r;
  logic [DIST_W-1:0]     last_dist_r;

  // Scan and divide registers
  logic [TW-1:0]         t_r;
  logic [AW-1:0]         n_r;
  logic [COUNT_BITS-1:0] cur_cum_r;
  logic [DIST_W-1:0]     cur_dist_r;
  logic [COUNT_BITS-1:0] prev_cum_r;
  logic [DIST_W-1:0]     prev_dist_r;
  logic [TW-1:0]         rem_r;
  logic [TW-1:0]         dv_r;
  logic [FRAC_W-1:0]     q_r;
  logic [KW-1:0]         k_r;
  logic [DIAM_W-1:0]     res_r;

  // Control
  edi_uword_t ctl;
  edi_flags_t flags;

  // Combinational datapath
  logic                              in_beat;
  logic                              out_beat;
  logic                              full;
  logic                              store;
  logic [COUNT_BITS-1:0]             cnt_sat;
  logic [COUNT_BITS:0]               sum;
  logic [COUNT_BITS-1:0]             sum_sat;
  logic [COUNT_BITS-1:0]             cum_in;
  logic [PCT_W-1:0]                  p_sat;
  logic [PLO_W-1:0]                  prod_lo;
  logic [PHI_W-1:0]                  prod_hi;
  logic [MEM_W-1:0]                  rd_data;
  logic [COUNT_BITS-1:0]             rd_cum;
  logic [DIST_W-1:0]                 rd_dist;
  logic [COUNT_BITS-1:0]             delta;
  logic                              ge;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
      pdf_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PERCENTILE:   pct_r <= pwdata[PCT_W-1:0];
        REG_INPUT_IS_PDF: pdf_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PERCENTILE:   prdata = CFG_DATA_W'(pct_r);
      REG_INPUT_IS_PDF: prdata = CFG_DATA_W'(pdf_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign in_ch.ready               = ctl.in_ready;
  assign out_ch.valid              = ctl.out_valid;
  assign out_ch.effective_diameter = res_r;
  assign out_ch.overflow           = ovf_r;
  assign in_beat                   = in_ch.valid && in_ch.ready;
  assign out_beat                  = out_ch.valid && out_ch.ready;

  // ---------------------------------------------------------------- loading
  // Saturate the incoming count, then fold it into the running sum in pdf mode.
  assign full    = (cnt_r == CNT_W'(MAX_ENTRIES));
  assign store   = in_beat && (ctl.op == OP_LOAD) && !full;
  assign cnt_sat = (in_ch.pair_count > PAIR_CAP) ? {COUNT_BITS{1'b1}}
                                                 : in_ch.pair_count[COUNT_BITS-1:0];
  assign sum     = {1'b0, run_r} + {1'b0, cnt_sat};
  assign sum_sat = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  assign cum_in  = pdf_r ? sum_sat : cnt_sat;

  edi_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({in_ch.distance, cum_in}),
    .raddr (n_r),
    .rdata (rd_data)
  );

  assign rd_cum  = rd_data[COUNT_BITS-1:0];
  assign rd_dist = rd_data[MEM_W-1:COUNT_BITS];

  // ---------------------------------------------------------------- arithmetic
  // Threshold product in two halves of the final count.
  assign p_sat   = (pct_r > PCT_ONE) ? PCT_ONE : pct_r;
  assign prod_lo = PLO_W'(p_sat) * PLO_W'(last_cum_r[HW-1:0]);
  assign prod_hi = PHI_W'(p_sat) * PHI_W'(last_cum_r[COUNT_BITS-1:HW]);
  assign delta   = cur_cum_r - prev_cum_r;
  assign ge      = (rem_r >= dv_r);

  // ---------------------------------------------------------------- flags
  assign flags.no_close = !(in_beat && in_ch.last_entry);
  assign flags.hit      = (TW'({rd_cum, {FRAC_W{1'b0}}}) > t_r);
  assign flags.more     = ((CNT_W'(n_r) + CNT_W'(1)) < cnt_r);
  assign flags.special  = (n_r == '0) || (cur_cum_r <= prev_cum_r);
  assign flags.div_more = (k_r != KW'(FRAC_W - 1));
  assign flags.out_wait = !out_ch.ready;

  edi_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  // ---------------------------------------------------------------- histogram state
  // Entry count, running sum and overflow restart after each result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      run_r <= '0;
      ovf_r <= 1'b0;
    end else if (ctl.op == OP_CLEAR) begin
      cnt_r <= '0;
      run_r <= '0;
      ovf_r <= 1'b0;
    end else if (in_beat && (ctl.op == OP_LOAD)) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (pdf_r) begin
          run_r <= sum_sat;
        end
      end
    end
  end

  // Keep the newest stored entry at hand for the threshold and the no-hit case.
  always_ff @(posedge clk) begin
    if (store) begin
      last_cum_r  <= cum_in;
      last_dist_r <= in_ch.distance;
    end
  end

  // ---------------------------------------------------------------- scan and divide
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_MUL_LO: begin
        t_r <= TW'(prod_lo);
        n_r <= '0;
      end
      OP_MUL_HI: begin
        t_r <= t_r + (TW'(prod_hi) << HW);
      end
      OP_CMP: begin
        cur_cum_r  <= rd_cum;
        cur_dist_r <= rd_dist;
      end
      OP_ADV: begin
        prev_cum_r  <= cur_cum_r;
        prev_dist_r <= cur_dist_r;
        n_r         <= n_r + AW'(1);
      end
      OP_RES_LAST: begin
        res_r <= {last_dist_r, {FRAC_W{1'b0}}};
      end
      OP_DIV_INIT: begin
        // Hit on the first entry gives one; a flat step gives its distance.
        if (n_r == '0) begin
          res_r <= DIAM_W'(PCT_ONE);
        end else begin
          res_r <= {cur_dist_r, {FRAC_W{1'b0}}};
        end
        rem_r <= t_r - TW'({prev_cum_r, {FRAC_W{1'b0}}});
        dv_r  <= TW'({delta, {(FRAC_W - 1){1'b0}}});
        q_r   <= '0;
        k_r   <= '0;
      end
      OP_DIV_STEP: begin
        if (ge) begin
          rem_r <= rem_r - dv_r;
        end
        q_r <= {q_r[FRAC_W-2:0], ge};
        dv_r <= dv_r >> 1;
        k_r <= k_r + KW'(1);
      end
      OP_RES_DIV: begin
        res_r <= {prev_dist_r, {FRAC_W{1'b0}}} + DIAM_W'(q_r);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- assertions
  // No entry is taken while a result is on offer.
  a_no_load_during_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("entry accepted while a result is pending");

  // The entry count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond store depth");

  // A divide step always has a nonzero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_DIV_STEP) |-> (dv_r != '0))
    else $error("divide step with zero divisor");

  // After a result beat the histogram state starts over.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> ##2 ((cnt_r == '0) && !ovf_r))
    else $error("histogram state not cleared after result");

  // A scan starts only after a closing entry beat.
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_MUL_LO) |-> $past(in_beat && in_ch.last_entry))
    else $error("threshold computed without a closing entry");

endmodule

// ===== sv/edi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module edi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/edi_seq.sv =====
// ----------------------------------------------------------------------------
// Effective diameter interpolator sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module edi_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  edi_pkg::edi_flags_t flags,
  output edi_pkg::edi_uword_t ctl
);
  import edi_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctl = ucode_rom(pc_r);

  // Evaluate the jump condition of the current step.
  always_comb begin
    case (ctl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_CLOSE: take = flags.no_close;
      C_HIT:      take = flags.hit;
      C_MORE:     take = flags.more;
      C_SPECIAL:  take = flags.special;
      C_DIV_MORE: take = flags.div_more;
      C_OUT_WAIT: take = flags.out_wait;
      default:    take = 1'b1;
    endcase
    pc_nxt = take ? ctl.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Effective diameter interpolator regression
// Streams distance histograms into the block under varying percentile and
// pdf settings, predicts each diameter beat with a local scoreboard and
// compares the result beats field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import edi_pkg::*;

  localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

  typedef struct {
    logic [DIAM_W-1:0] diam;
    logic              ovf;
  } diam_result_t;

  // Scoreboard: local copy of the histogram store and the registers, plus the
  // queue of diameter beats still owed by the block.
  class diameter_scoreboard;
    logic [DIST_W-1:0] dist_mem [MAX_ENTRIES_DEF];
    logic [PAIR_W-1:0] cum_mem  [MAX_ENTRIES_DEF];
    int                n_stored;
    logic [PAIR_W-1:0] pdf_sum;
    bit                ovf_seen;
    logic [PCT_W-1:0]  pct;
    bit                pdf_mode;
    diam_result_t      owed_q[$];
    int                errors;

    function new();
      n_stored = 0;
      pdf_sum  = '0;
      ovf_seen = 1'b0;
      pct      = PCT_RESET;
      pdf_mode = 1'b0;
      errors   = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_PERCENTILE) begin
        pct = val[PCT_W-1:0];
      end else if (idx == REG_INPUT_IS_PDF) begin
        pdf_mode = val[0];
      end
    endfunction

    // Threshold scan and linear interpolation over the stored entries.
    function logic [DIAM_W-1:0] interpolate();
      logic [63:0] p;
      logic [63:0] thr;
      logic [63:0] prev;
      logic [63:0] here;
      logic [63:0] delta;
      logic [63:0] frac;
      int n;
      if (n_stored == 0) return '0;
      p   = (pct > PCT_ONE) ? 64'(PCT_ONE) : 64'(pct);
      thr = p * {16'd0, cum_mem[n_stored-1]};
      for (n = 0; n < n_stored; n++) begin
        if ({cum_mem[n], 16'd0} > thr) break;
      end
      // Nothing above the threshold: the last distance stands.
      if (n >= n_stored) return {dist_mem[n_stored-1], 16'd0};
      // The very first entry already exceeds it.
      if (n == 0) return {8'd1, 16'd0};
      prev = {16'd0, cum_mem[n-1]};
      here = {16'd0, cum_mem[n]};
      if (here <= prev) return {dist_mem[n], 16'd0};
      delta = here - prev;
      frac  = (thr - {prev[47:0], 16'd0}) / delta;
      if (frac > 64'hFFFF) frac = 64'hFFFF;
      return {dist_mem[n-1], frac[15:0]};
    endfunction

    // Called for every accepted histogram beat.
    function void note_entry(logic [DIST_W-1:0] d, logic [PAIR_W-1:0] c, logic l);
      logic [PAIR_W-1:0] cum;
      diam_result_t r;
      if (n_stored < MAX_ENTRIES_DEF) begin
        if (pdf_mode) begin
          pdf_sum = (c > PAIR_MAX - pdf_sum) ? PAIR_MAX : pdf_sum + c;
          cum = pdf_sum;
        end else begin
          cum = c;
        end
        dist_mem[n_stored] = d;
        cum_mem[n_stored]  = cum;
        n_stored++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (l) begin
        r.diam = interpolate();
        r.ovf  = ovf_seen;
        owed_q.push_back(r);
        n_stored = 0;
        pdf_sum  = '0;
        ovf_seen = 1'b0;
      end
    endfunction

    // Called for every accepted result beat.
    task check_result(input logic [DIAM_W-1:0] diam, input logic ovf);
      diam_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, diameter %h", diam));
        return;
      end
      want = owed_q.pop_front();
      if (diam !== want.diam)
        report_mismatch($sformatf("effective_diameter %h, predicted %h", diam, want.diam));
      if (ovf !== want.ovf)
        report_mismatch($sformatf("overflow %b, predicted %b", ovf, want.ovf));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  edi_in_if  in_bus();
  edi_out_if out_bus();

  diameter_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  effective_diameter_interpolator u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitors: both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.note_entry(in_bus.distance, in_bus.pair_count, in_bus.last_entry);
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result(out_bus.effective_diameter, out_bus.overflow);
  end

  // Result receiver: random stalls, plus long hold-offs counted here.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("effective_diameter_interpolator regression: fail");
    $finish;
  end

  // Offer one histogram beat and wait until it is taken.
  task automatic send_entry(input logic [DIST_W-1:0] d, input logic [PAIR_W-1:0] c,
                            input logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.distance   <= d;
    in_bus.pair_count <= c;
    in_bus.last_entry <= l;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Drop valid and wait until every owed result beat has been taken.
  task automatic wait_for_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    // Let the block finish its clearing step before anything else happens.
    repeat (8) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One histogram. Tidy ones climb in distance and count (or carry per
  // distance counts in pdf mode); the others carry arbitrary fields.
  task automatic send_histogram(input int len, input bit tidy);
    logic [DIST_W-1:0] d;
    logic [PAIR_W-1:0] c;
    logic [PAIR_W-1:0] acc;
    logic [PAIR_W-1:0] step;
    int sh;
    int i;
    d   = DIST_W'($urandom_range(0, 40));
    acc = '0;
    sh  = $urandom_range(0, 32);
    for (i = 0; i < len; i++) begin
      if (tidy) begin
        step = PAIR_W'($urandom_range(0, 65535)) << sh;
        if (sb.pdf_mode) begin
          c = step;
        end else begin
          acc = (step > PAIR_MAX - acc) ? PAIR_MAX : acc + step;
          c   = acc;
        end
        d = d + DIST_W'($urandom_range(1, 3));
      end else begin
        c = {16'($urandom), 32'($urandom)};
        d = DIST_W'($urandom);
      end
      send_entry(d, c, i == len - 1);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] pct_val;
    int sent;
    int len;
    int p;

    sb = new();
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_bus.valid      = 1'b0;
    in_bus.distance   = '0;
    in_bus.pair_count = '0;
    in_bus.last_entry = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, cumulative counts.
    send_entry(8'd0, '0, 1'b1);                 // zero count, nothing exceeds
    send_entry(8'd255, PAIR_MAX, 1'b1);         // first entry exceeds
    send_entry(8'd1, 48'd100, 1'b0);            // plain interpolation
    send_entry(8'd2, 48'd500, 1'b0);
    send_entry(8'd3, 48'd1000, 1'b1);
    wait_for_results();

    // Zero percentile: the first nonzero count is the hit.
    cfg_write(REG_PERCENTILE, '0);
    send_entry(8'd5, '0, 1'b0);
    send_entry(8'd6, '0, 1'b0);
    send_entry(8'd7, 48'd10, 1'b0);
    send_entry(8'd9, 48'd20, 1'b1);
    wait_for_results();

    // Percentile of one, with a count that falls back below an earlier one.
    cfg_write(REG_PERCENTILE, 32'(PCT_ONE));
    send_entry(8'd1, 48'd10, 1'b0);
    send_entry(8'd2, 48'd50, 1'b0);
    send_entry(8'd3, 48'd20, 1'b1);
    wait_for_results();

    // Percentile above one is clipped to one.
    cfg_write(REG_PERCENTILE, 32'h1FFFF);
    send_entry(8'd10, 48'd7, 1'b0);
    send_entry(8'd20, 48'd7, 1'b1);
    wait_for_results();

    // Pdf mode with a running sum that saturates.
    cfg_write(REG_PERCENTILE, 32'(PCT_RESET));
    cfg_write(REG_INPUT_IS_PDF, 32'd1);
    send_entry(8'd1, PAIR_MAX, 1'b0);
    send_entry(8'd2, 48'd5, 1'b0);
    send_entry(8'd3, 48'hFFFF_FFFF_FFF0, 1'b1);
    wait_for_results();

    // Mode switched in the middle of a histogram; the sum carries over.
    send_entry(8'd4, 48'd100, 1'b0);
    send_entry(8'd5, 48'd200, 1'b0);
    wait_for_results();
    cfg_write(REG_INPUT_IS_PDF, 32'd0);
    send_entry(8'd6, 48'd50, 1'b0);
    wait_for_results();
    cfg_write(REG_INPUT_IS_PDF, 32'd1);
    send_entry(8'd7, 48'd10, 1'b1);
    wait_for_results();

    // Random phases: percentile and mode per phase, idling pattern cycling.
    for (p = 0; p < 8; p++) begin
      case (p)
        0: pct_val = '0;
        1: pct_val = 32'(PCT_ONE);
        2: pct_val = 32'h1FFFF;
        3: pct_val = 32'(PCT_RESET);
        4: pct_val = 32'($urandom_range(0, 65536));
        5: pct_val = 32'($urandom_range(0, 131071));
        6: pct_val = 32'd1;
        default: pct_val = 32'd65535;
      endcase
      cfg_write(REG_PERCENTILE, pct_val);
      cfg_write(REG_INPUT_IS_PDF, 32'(p / 4));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      // Long receiver hold-off: a pending result stalls the block's input.
      if (p % 4 == 0) begin
        hold_left = 400;
        send_histogram(3, 1'b1);
        send_histogram(4, 1'b1);
        wait_for_results();
      end
      sent = 0;
      while (sent < 30) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_histogram(len, $urandom_range(99) < 85);
        sent += len;
        if ($urandom_range(7) == 0) wait_for_results();
      end
      wait_for_results();
    end

    // A histogram longer than the store: overflow reported, extras dropped.
    send_idle_pct  = 0;
    recv_stall_pct = 26;
    cfg_write(REG_PERCENTILE, 32'($urandom_range(0, 65536)));
    cfg_write(REG_INPUT_IS_PDF, '0);
    send_histogram(MAX_ENTRIES_DEF + 2, 1'b1);
    wait_for_results();

    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("effective_diameter_interpolator regression: pass");
    end else begin
      $display("effective_diameter_interpolator regression: fail");
    end
    $finish;
  end

endmodule
